FILE: sv/sp2a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sp2a_pkg
// Shared types, codes and helper functions for the power-of-two segregated
// free-list allocator.
// ----------------------------------------------------------------------------
package sp2a_pkg;

    // Field and datapath widths fixed by the item formats.
    localparam int REQ_W  = 18;
    localparam int ADDR_W = 18;
    localparam int NEED_W = REQ_W + 1;
    localparam int SZ_W   = 20;
    localparam int IDX_W  = 5;
    localparam int WORD_W = 32;

    // Operation codes.
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_REINIT = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_NOMEM = 2'd2;

    // Heap layout constants.
    localparam int          HEAP_BASE     = 8;
    localparam int          MIN_BLOCK     = 8;
    localparam int          HDR_BYTES     = 4;
    localparam int          CLASS_SHIFT   = 3;
    localparam logic [31:0] WORD_ZERO     = 32'h0000_0000;
    localparam logic [31:0] EPILOGUE_WORD = 32'h0000_0001;
    localparam logic [31:0] ALLOC_FLAG    = 32'h0000_0001;
    localparam logic [31:0] HDR_SIZE_MASK = 32'hFFFF_FFF8;

    typedef struct packed {
        logic [1:0]        op;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] block_addr;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] payload_addr;
        logic [1:0]        status;
    } t_out_item;

    // Handshake status from the sequencer to the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_stat;

    // Class of an allocation: ceil(log2(need)) - 3, for need of at least 5.
    function automatic logic [IDX_W-1:0] alloc_class(input logic [NEED_W-1:0] need);
        logic [NEED_W-1:0] m;
        logic [IDX_W-1:0]  p;
        m = need - NEED_W'(1);
        p = '0;
        for (int i = 0; i < NEED_W; i++) begin
            if (m[i]) begin
                p = IDX_W'(i);
            end
        end
        return p - IDX_W'(2);
    endfunction

    // Bit position of a one-hot word.
    function automatic logic [IDX_W-1:0] onehot_index(input logic [WORD_W-1:0] h);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (h[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

FILE: sv/segregated_pow2_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segregated_pow2_allocator_unit
// Power-of-two segregated free-list allocator over a word-addressed heap.
//
//   Channel  Direction  Handshake                Item
//   input    in         i_in_valid/o_in_ready    t_in_item  (op, size, address)
//   output   out        o_out_valid/i_out_ready  t_out_item (address, status)
//
// One item is in work at a time; every item gives one result. An allocation
// served from a class list reads the head block's header, then marks it
// allocated; a free reads the block's header, then pushes it; a reinitialise
// writes heap words 0 and 1; a rejected request goes straight to its result.
// An allocation whose list is empty first grows the heap, placing the
// epilogue, and links each block carved from the new area. All accesses go to
// the single-port heap RAM, whose read data are registered. A waiting result
// holds the sequencer in its done state, so no new item is accepted meanwhile.
// Reset is immediate: no clearing pass; heap words are undefined until written.
// ----------------------------------------------------------------------------
module segregated_pow2_allocator_unit import sp2a_pkg::*; #(
    parameter int HEAP_WORDS  = 65536,
    parameter int NUM_CLASSES = 16,
    parameter int CHUNK_BYTES = 4096
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    localparam int WA = $clog2(HEAP_WORDS);

    t_seq_stat         seq_stat;
    t_out_item         seq_res;
    logic              ram_en;
    logic              ram_we;
    logic [WA-1:0]     ram_addr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic              slot_free;
    logic              r_out_valid;
    t_out_item         r_out_item;

    // The output register is free once empty or being taken.
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = seq_stat.idle;

    sp2a_seq #(
        .HEAP_WORDS  (HEAP_WORDS),
        .NUM_CLASSES (NUM_CLASSES),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && seq_stat.idle),
        .i_item      (i_in_item),
        .i_slot_free (slot_free),
        .o_stat      (seq_stat),
        .o_res       (seq_res),
        .o_ram_en    (ram_en),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata)
    );

    sp2a_heap_ram #(
        .DEPTH (HEAP_WORDS)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output item register.
    always_ff @(posedge i_clk) begin
        if (seq_stat.done) begin
            r_out_item <= seq_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

FILE: sv/sp2a_heap_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sp2a_heap_ram
// Single-port word memory holding the heap, with registered read data.
// ----------------------------------------------------------------------------
module sp2a_heap_ram import sp2a_pkg::*; #(
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WORD_W-1:0]        i_wdata,
    output logic      [WORD_W-1:0]        o_rdata
);

    logic [WORD_W-1:0] mem [DEPTH];

    // One access per cycle: a write, or a read whose data is registered.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= mem[i_addr];
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/sp2a_addcmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sp2a_addcmp
// Shared adder and magnitude comparator: sum = a + b, gt = (sum > c).
// ----------------------------------------------------------------------------
module sp2a_addcmp #(
    parameter int W = 21
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic [W-1:0] i_c,
    output logic      [W-1:0] o_sum,
    output logic              o_gt
);

    // Operands are kept narrow enough by the caller that the sum never wraps.
    assign o_sum = i_a + i_b;
    assign o_gt  = (o_sum > i_c);

endmodule
`default_nettype wire

FILE: sv/sp2a_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sp2a_seq
// Sequencer of the allocator: class lookup, heap growth and carving, list
// pop and push, all through one shared adder-comparator and the heap RAM.
// ----------------------------------------------------------------------------
module sp2a_seq import sp2a_pkg::*; #(
    parameter int HEAP_WORDS  = 65536,
    parameter int NUM_CLASSES = 16,
    parameter int CHUNK_BYTES = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire t_in_item                      i_item,
    input  wire logic                          i_slot_free,
    output t_seq_stat                          o_stat,
    output t_out_item                          o_res,
    output logic                               o_ram_en,
    output logic                               o_ram_we,
    output logic [$clog2(HEAP_WORDS)-1:0]      o_ram_addr,
    output logic [WORD_W-1:0]                  o_ram_wdata,
    input  wire logic [WORD_W-1:0]             i_ram_rdata
);

    localparam int WA          = $clog2(HEAP_WORDS);
    localparam int TOP_W       = $clog2(HEAP_WORDS * 4 + 1);
    localparam int CLS_W       = $clog2(NUM_CLASSES);
    localparam int UW          = ((TOP_W > SZ_W) ? TOP_W : SZ_W) + 1;
    localparam int HEAP_BYTES  = HEAP_WORDS * 4;
    localparam int CHUNK_WORDS = CHUNK_BYTES / 4;
    localparam int CHUNK_EXT   = (CHUNK_WORDS + (CHUNK_WORDS % 2)) * 4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_GROW,
        S_CARVE,
        S_POP_RD,
        S_POP_WR,
        S_FREE_WR,
        S_REINIT1,
        S_DONE
    } t_state;

    // Word index of the header just below a payload address.
    function automatic logic [WA-1:0] hdr_word(input logic [TOP_W-1:0] bp);
        logic [TOP_W-1:0] hb;
        hb = bp - TOP_W'(HDR_BYTES);
        return hb[WA+1:2];
    endfunction

    t_state              r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [REQ_W-1:0]    r_req, n_req;
    logic [ADDR_W-1:0]   r_blk, n_blk;
    logic [CLS_W-1:0]    r_cls, n_cls;
    logic [SZ_W-1:0]     r_sz, n_sz;
    logic [SZ_W-1:0]     r_ext, n_ext;
    logic [TOP_W-1:0]    r_bp, n_bp;
    logic [TOP_W-1:0]    r_top_m4, n_top_m4;
    logic [TOP_W-1:0]    r_heap_top, n_heap_top;
    logic [TOP_W-1:0]    r_heads [NUM_CLASSES];
    logic [TOP_W-1:0]    n_heads [NUM_CLASSES];
    t_out_item           r_res, n_res;

    // Shared unit operands and results.
    logic [UW-1:0]       u_a, u_b, u_c, u_sum;
    logic                u_gt;

    // Allocation class decode.
    logic [NEED_W-1:0]   need;
    logic [IDX_W-1:0]    acls;
    logic                acls_ok;
    logic [CLS_W-1:0]    acls_i;
    logic [SZ_W-1:0]     asz;
    logic [SZ_W-1:0]     aext;

    // Free decode.
    logic [UW-1:0]       blk_u;
    logic [TOP_W-1:0]    blk_top;
    logic                blk_ok;
    logic [WORD_W-1:0]   hsz;
    logic                hpow2;
    logic [IDX_W-1:0]    hidx;
    logic [IDX_W-1:0]    hcls_full;
    logic                hcls_ok;
    logic [CLS_W-1:0]    hcls;

    // Pop decode.
    logic [TOP_W-1:0]    nxt_lo;
    logic                nxt_ok;

    sp2a_addcmp #(
        .W (UW)
    ) u_addcmp (
        .i_a   (u_a),
        .i_b   (u_b),
        .i_c   (u_c),
        .o_sum (u_sum),
        .o_gt  (u_gt)
    );

    // Class, block size and growth amount of an allocation.
    always_comb begin
        need    = NEED_W'(r_req) + NEED_W'(HDR_BYTES);
        acls    = alloc_class(need);
        acls_ok = ({1'b0, acls} < (IDX_W + 1)'(NUM_CLASSES));
        acls_i  = acls[CLS_W-1:0];
        asz     = SZ_W'(1) << (acls + IDX_W'(CLASS_SHIFT));
        aext    = (asz > SZ_W'(CHUNK_EXT)) ? asz : SZ_W'(CHUNK_EXT);
    end

    // Checks on a freed address and on the header read back for it.
    always_comb begin
        blk_u     = UW'(r_blk);
        blk_top   = blk_u[TOP_W-1:0];
        blk_ok    = (r_blk[1:0] == 2'b00) && (r_blk >= ADDR_W'(MIN_BLOCK)) && !u_gt;
        hsz       = i_ram_rdata & HDR_SIZE_MASK;
        hpow2     = (hsz != WORD_ZERO) && ((hsz & (hsz - 32'd1)) == WORD_ZERO);
        hidx      = onehot_index(hsz);
        hcls_ok   = hpow2 && ({1'b0, hidx} < (IDX_W + 1)'(NUM_CLASSES + CLASS_SHIFT));
        hcls_full = hidx - IDX_W'(CLASS_SHIFT);
        hcls      = hcls_full[CLS_W-1:0];
    end

    // A next link that is not a valid address ends the list.
    always_comb begin
        nxt_lo = i_ram_rdata[TOP_W-1:0];
        nxt_ok = (i_ram_rdata[WORD_W-1:TOP_W] == '0) && (nxt_lo[1:0] == 2'b00)
                 && (nxt_lo >= TOP_W'(MIN_BLOCK)) && !u_gt;
    end

    // Operand selection for the shared unit.
    always_comb begin
        u_a = '0;
        u_b = '0;
        u_c = '0;
        unique case (r_state)
            S_CLASS: begin
                // blk + 1 > heap_top means blk is at or beyond the heap top.
                u_a = blk_u;
                u_b = UW'(1);
                u_c = UW'(r_heap_top);
            end
            S_GROW: begin
                u_a = UW'(r_heap_top);
                u_b = UW'(r_ext);
                u_c = UW'(HEAP_BYTES);
            end
            S_CARVE: begin
                u_a = UW'(r_bp);
                u_b = UW'(r_sz);
                u_c = UW'(r_top_m4);
            end
            S_POP_WR: begin
                u_a = UW'(nxt_lo);
                u_b = UW'(1);
                u_c = UW'(r_heap_top);
            end
            default: begin
                u_a = '0;
            end
        endcase
    end

    // Next-state and memory control.
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_req      = r_req;
        n_blk      = r_blk;
        n_cls      = r_cls;
        n_sz       = r_sz;
        n_ext      = r_ext;
        n_bp       = r_bp;
        n_top_m4   = r_top_m4;
        n_heap_top = r_heap_top;
        n_heads    = r_heads;
        n_res      = r_res;
        o_ram_en    = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_addr  = hdr_word(r_bp);
        o_ram_wdata = WORD_ZERO;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_item.op;
                    n_req   = i_item.request_bytes;
                    n_blk   = i_item.block_addr;
                    n_res   = '0;
                    n_state = S_CLASS;
                end
            end

            S_CLASS: begin
                case (r_op)
                    OP_ALLOC: begin
                        if (r_req == '0) begin
                            n_res.status = ST_ZERO;
                            n_state      = S_DONE;
                        end else if (!acls_ok) begin
                            n_res.status = ST_NOMEM;
                            n_state      = S_DONE;
                        end else begin
                            n_cls = acls_i;
                            n_sz  = asz;
                            n_ext = aext;
                            if (r_heads[acls_i] == '0) begin
                                n_state = S_GROW;
                            end else begin
                                n_state = S_POP_RD;
                            end
                        end
                    end
                    OP_FREE: begin
                        if (blk_ok) begin
                            o_ram_en   = 1'b1;
                            o_ram_addr = hdr_word(blk_top);
                            n_bp       = blk_top;
                            n_state    = S_FREE_WR;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_REINIT: begin
                        o_ram_en    = 1'b1;
                        o_ram_we    = 1'b1;
                        o_ram_addr  = '0;
                        o_ram_wdata = WORD_ZERO;
                        n_heap_top  = TOP_W'(HEAP_BASE);
                        for (int i = 0; i < NUM_CLASSES; i++) begin
                            n_heads[i] = '0;
                        end
                        n_state = S_REINIT1;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Grow heap, place epilogue, list new area; or report no memory.
            S_GROW: begin
                if (u_gt) begin
                    n_res.status = ST_NOMEM;
                    n_state      = S_DONE;
                end else begin
                    n_heap_top     = u_sum[TOP_W-1:0];
                    n_top_m4       = u_sum[TOP_W-1:0] - TOP_W'(HDR_BYTES);
                    o_ram_en       = 1'b1;
                    o_ram_we       = 1'b1;
                    o_ram_addr     = hdr_word(u_sum[TOP_W-1:0]);
                    o_ram_wdata    = EPILOGUE_WORD;
                    n_bp           = r_heap_top;
                    n_heads[r_cls] = r_heap_top;
                    n_state        = S_CARVE;
                end
            end

            // One block linked per cycle; the last one gets a null link.
            S_CARVE: begin
                o_ram_en   = 1'b1;
                o_ram_we   = 1'b1;
                o_ram_addr = hdr_word(r_bp);
                if (u_gt) begin
                    o_ram_wdata = WORD_ZERO;
                    n_state     = S_POP_RD;
                end else begin
                    o_ram_wdata = WORD_W'(u_sum);
                    n_bp        = u_sum[TOP_W-1:0];
                end
            end

            S_POP_RD: begin
                o_ram_en   = 1'b1;
                o_ram_addr = hdr_word(r_heads[r_cls]);
                n_bp       = r_heads[r_cls];
                n_state    = S_POP_WR;
            end

            // Mark the head block allocated and advance the list.
            S_POP_WR: begin
                o_ram_en       = 1'b1;
                o_ram_we       = 1'b1;
                o_ram_addr     = hdr_word(r_bp);
                o_ram_wdata    = WORD_W'(r_sz) | ALLOC_FLAG;
                n_heads[r_cls] = nxt_ok ? nxt_lo : '0;
                n_res.payload_addr = blk_addr_out(r_bp);
                n_res.status   = ST_OK;
                n_state        = S_DONE;
            end

            // Push the freed block when its header names a known class.
            S_FREE_WR: begin
                if (hcls_ok) begin
                    o_ram_en      = 1'b1;
                    o_ram_we      = 1'b1;
                    o_ram_addr    = hdr_word(r_bp);
                    o_ram_wdata   = WORD_W'(r_heads[hcls]);
                    n_heads[hcls] = r_bp;
                end
                n_state = S_DONE;
            end

            S_REINIT1: begin
                o_ram_en    = 1'b1;
                o_ram_we    = 1'b1;
                o_ram_addr  = WA'(1);
                o_ram_wdata = EPILOGUE_WORD;
                n_state     = S_DONE;
            end

            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Payload address field from an internal heap address.
    function automatic logic [ADDR_W-1:0] blk_addr_out(input logic [TOP_W-1:0] bp);
        logic [UW-1:0] w;
        w = UW'(bp);
        return w[ADDR_W-1:0];
    endfunction

    // State, heap top and class heads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_heap_top <= TOP_W'(HEAP_BASE);
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_heads[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_heap_top <= n_heap_top;
            r_heads    <= n_heads;
            r_op       <= n_op;
            r_req      <= n_req;
            r_blk      <= n_blk;
            r_cls      <= n_cls;
            r_sz       <= n_sz;
            r_ext      <= n_ext;
            r_bp       <= n_bp;
            r_top_m4   <= n_top_m4;
            r_res      <= n_res;
        end
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE) && i_slot_free;
    assign o_res       = r_res;

endmodule
`default_nettype wire
